// ===== hdl/bmp_pkg.sv =====
package bmp_pkg;

    localparam int VAL_W     = 20;
    localparam int IDX_W     = 15;
    localparam int IDX_MAX   = 32767;
    localparam int JOB_DEPTH = 4;
    localparam int OUT_DEPTH = 32;

    localparam logic [VAL_W-1:0] PRIME     = 20'd1000003;
    localparam logic [VAL_W-1:0] PRIME_EXP = 20'd1000001;
    // 2^20 mod p, used to fold the high part of a product back down
    localparam logic [15:0]      FOLD      = 16'd48573;

    typedef struct packed {
        logic signed [15:0] total_count;
        logic signed [15:0] chosen_count;
    } query_t;

    typedef struct packed {
        logic [VAL_W-1:0] coefficient;
        logic             beyond_table;
    } result_t;

    typedef struct packed {
        logic             ok;
        logic             beyond;
        logic [IDX_W-1:0] n;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] d;
    } job_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [VAL_W-1:0] data;
    } tbl_wr_t;

endpackage

// ===== hdl/bmp_ram.sv =====
module bmp_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/bmp_fifo.sv =====
module bmp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = push && !full;
    assign do_rd = pop && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/bmp_mulmod.sv =====
module bmp_mulmod #(
    parameter int TAG_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [bmp_pkg::VAL_W-1:0] a,
    input  logic [bmp_pkg::VAL_W-1:0] b,
    input  logic [TAG_W-1:0]          in_tag,
    output logic                      out_valid,
    output logic [bmp_pkg::VAL_W-1:0] res,
    output logic [TAG_W-1:0]          out_tag
);

    import bmp_pkg::*;

    localparam int LAT = 7;

    logic [LAT-1:0]   valid_reg;
    logic [TAG_W-1:0] tag_reg [LAT];

    logic [39:0]      prod_reg, prod_next;
    logic [36:0]      f1_reg, f1_next;
    logic [33:0]      f2_reg, f2_next;
    logic [30:0]      f3_reg, f3_next;
    logic [26:0]      f4_reg, f4_next;
    logic [22:0]      f5_reg, f5_next;
    logic [20:0]      fin;
    logic [VAL_W-1:0] res_reg, res_next;

    // each fold replaces hi * 2^20 by hi * (2^20 mod p)
    always_comb
    begin
        prod_next = 40'(a) * 40'(b);
        f1_next   = 37'(prod_reg[39:20]) * 37'(FOLD) + 37'(prod_reg[19:0]);
        f2_next   = 34'(f1_reg[36:20]) * 34'(FOLD) + 34'(f1_reg[19:0]);
        f3_next   = 31'(f2_reg[33:20]) * 31'(FOLD) + 31'(f2_reg[19:0]);
        f4_next   = 27'(f3_reg[30:20]) * 27'(FOLD) + 27'(f3_reg[19:0]);
        f5_next   = 23'(f4_reg[26:20]) * 23'(FOLD) + 23'(f4_reg[19:0]);
        // below 2p here, one subtract finishes it
        fin       = 21'(f5_reg[22:20]) * 21'(FOLD) + 21'(f5_reg[19:0]);
        res_next  = (fin >= 21'(PRIME)) ? VAL_W'(fin - 21'(PRIME)) : fin[VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= in_tag;
        for (int k = 1; k < LAT; k++)
        begin
            tag_reg[k] <= tag_reg[k-1];
        end
        prod_reg <= prod_next;
        f1_reg   <= f1_next;
        f2_reg   <= f2_next;
        f3_reg   <= f3_next;
        f4_reg   <= f4_next;
        f5_reg   <= f5_next;
        res_reg  <= res_next;
    end

    assign out_valid = valid_reg[LAT-1];
    assign out_tag   = tag_reg[LAT-1];
    assign res       = res_reg;

endmodule

// ===== hdl/bmp_init.sv =====
module bmp_init #(
    parameter int TABLE_TOP = 4095
) (
    input  logic             clk,
    input  logic             rst_n,
    output logic             ready,
    output bmp_pkg::tbl_wr_t fac_wr,
    output bmp_pkg::tbl_wr_t ifac_wr
);

    import bmp_pkg::*;

    localparam logic [3:0] ST_FAC_START = 4'd0;
    localparam logic [3:0] ST_FAC_ISSUE = 4'd1;
    localparam logic [3:0] ST_FAC_WAIT  = 4'd2;
    localparam logic [3:0] ST_POW_STEP  = 4'd3;
    localparam logic [3:0] ST_POW_MWAIT = 4'd4;
    localparam logic [3:0] ST_POW_SQR   = 4'd5;
    localparam logic [3:0] ST_POW_SWAIT = 4'd6;
    localparam logic [3:0] ST_INV_ISSUE = 4'd7;
    localparam logic [3:0] ST_INV_WAIT  = 4'd8;
    localparam logic [3:0] ST_DONE      = 4'd9;

    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(TABLE_TOP);

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [VAL_W-1:0] cur_reg, cur_next;
    logic [VAL_W-1:0] acc_reg, acc_next;
    logic [VAL_W-1:0] base_reg, base_next;
    logic [VAL_W-1:0] exp_reg, exp_next;

    logic             mul_valid;
    logic [VAL_W-1:0] mul_a;
    logic [VAL_W-1:0] mul_b;
    logic             mul_done;
    logic [VAL_W-1:0] mul_res;

    bmp_mulmod #(
        .TAG_W (1)
    ) u_mulmod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .a         (mul_a),
        .b         (mul_b),
        .in_tag    (1'b0),
        .out_valid (mul_done),
        .res       (mul_res),
        .out_tag   ()
    );

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        acc_next     = acc_reg;
        base_next    = base_reg;
        exp_next     = exp_reg;
        mul_valid    = 1'b0;
        mul_a        = cur_reg;
        mul_b        = VAL_W'(idx_reg);
        fac_wr.en    = 1'b0;
        fac_wr.addr  = idx_reg;
        fac_wr.data  = mul_res;
        ifac_wr.en   = 1'b0;
        ifac_wr.addr = idx_reg;
        ifac_wr.data = mul_res;

        unique case (state_reg)
            ST_FAC_START:
            begin
                fac_wr.en   = 1'b1;
                fac_wr.addr = '0;
                fac_wr.data = VAL_W'(1);
                cur_next    = VAL_W'(1);
                idx_next    = IDX_W'(1);
                state_next  = ST_FAC_ISSUE;
            end
            ST_FAC_ISSUE:
            begin
                mul_valid  = 1'b1;
                state_next = ST_FAC_WAIT;
            end
            ST_FAC_WAIT:
            begin
                if (mul_done)
                begin
                    cur_next  = mul_res;
                    fac_wr.en = 1'b1;
                    if (idx_reg == TOP_IDX)
                    begin
                        base_next  = mul_res;
                        acc_next   = VAL_W'(1);
                        exp_next   = PRIME_EXP;
                        state_next = ST_POW_STEP;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_FAC_ISSUE;
                    end
                end
            end
            ST_POW_STEP:
            begin
                if (exp_reg == '0)
                begin
                    // inverse of the top factorial, then walk down
                    ifac_wr.en   = 1'b1;
                    ifac_wr.data = acc_reg;
                    cur_next     = acc_reg;
                    state_next   = ST_INV_ISSUE;
                end
                else if (exp_reg[0])
                begin
                    mul_valid  = 1'b1;
                    mul_a      = acc_reg;
                    mul_b      = base_reg;
                    state_next = ST_POW_MWAIT;
                end
                else
                begin
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_MWAIT:
            begin
                if (mul_done)
                begin
                    acc_next   = mul_res;
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_SQR:
            begin
                mul_valid  = 1'b1;
                mul_a      = base_reg;
                mul_b      = base_reg;
                state_next = ST_POW_SWAIT;
            end
            ST_POW_SWAIT:
            begin
                if (mul_done)
                begin
                    base_next  = mul_res;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_POW_STEP;
                end
            end
            ST_INV_ISSUE:
            begin
                mul_valid  = 1'b1;
                state_next = ST_INV_WAIT;
            end
            ST_INV_WAIT:
            begin
                if (mul_done)
                begin
                    // 1/(i-1)! = i * 1/i!
                    cur_next     = mul_res;
                    ifac_wr.en   = 1'b1;
                    ifac_wr.addr = idx_reg - IDX_W'(1);
                    if (idx_reg == IDX_W'(1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = ST_INV_ISSUE;
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_DONE;
            end
            default:
            begin
                state_next = ST_FAC_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FAC_START;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
    end

    assign ready = (state_reg == ST_DONE);

endmodule

// ===== hdl/bmp_front.sv =====
module bmp_front #(
    parameter int TABLE_TOP = 4095
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  bmp_pkg::query_t query,
    input  logic            job_pop,
    output logic            job_empty,
    output bmp_pkg::job_t   job
);

    import bmp_pkg::*;

    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(TABLE_TOP);

    job_t             job_in;
    logic [15:0]      n;
    logic [15:0]      r;
    logic             beyond;
    logic             ok;
    logic [$bits(job_t)-1:0] job_bits;

    assign n = query.total_count;
    assign r = query.chosen_count;

    // invalid queries carry index zero so the table reads stay in range
    always_comb
    begin
        beyond     = !n[15] && (n[IDX_W-1:0] > TOP_IDX);
        ok         = !n[15] && !r[15] && (r[IDX_W-1:0] <= n[IDX_W-1:0]) && !beyond;
        job_in.ok     = ok;
        job_in.beyond = beyond;
        job_in.n      = ok ? n[IDX_W-1:0] : '0;
        job_in.r      = ok ? r[IDX_W-1:0] : '0;
        job_in.d      = ok ? (n[IDX_W-1:0] - r[IDX_W-1:0]) : '0;
    end

    bmp_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job_in),
        .full  (full),
        .pop   (job_pop),
        .rdata (job_bits),
        .empty (job_empty)
    );

    assign job = job_t'(job_bits);

endmodule

// ===== hdl/bmp_back.sv =====
module bmp_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      ready,
    input  logic                      job_empty,
    input  bmp_pkg::job_t             job,
    output logic                      job_pop,
    input  logic [bmp_pkg::VAL_W-1:0] fac_data,
    input  logic [bmp_pkg::VAL_W-1:0] ifac_r_data,
    input  logic [bmp_pkg::VAL_W-1:0] ifac_d_data,
    input  logic                      pop,
    output logic                      empty,
    output bmp_pkg::result_t          result
);

    import bmp_pkg::*;

    localparam int PEND_W = $clog2(OUT_DEPTH + 1);

    logic              issue;
    logic              rd_valid_reg;
    logic              rd_ok_reg;
    logic              rd_beyond_reg;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              out_full;
    logic              out_taken;

    logic              m1_valid;
    logic [VAL_W-1:0]  m1_res;
    logic [VAL_W+1:0]  m1_tag;
    logic              m2_valid;
    logic [VAL_W-1:0]  m2_res;
    logic [1:0]        m2_tag;
    result_t           res_in;
    logic [$bits(result_t)-1:0] res_bits;

    // pend counts words in flight plus words queued, so the output queue never overflows
    assign issue     = ready && !job_empty && (pend_reg < PEND_W'(OUT_DEPTH));
    assign job_pop   = issue;
    assign out_taken = pop && !empty;

    always_comb
    begin
        pend_next = pend_reg;
        if (issue && !out_taken)
        begin
            pend_next = pend_reg + PEND_W'(1);
        end
        else if (out_taken && !issue)
        begin
            pend_next = pend_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            pend_reg     <= '0;
        end
        else
        begin
            rd_valid_reg <= issue;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ok_reg     <= job.ok;
        rd_beyond_reg <= job.beyond;
    end

    // n! * 1/r!, with 1/(n-r)! riding along for the second product
    bmp_mulmod #(
        .TAG_W (VAL_W + 2)
    ) u_mul_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid_reg),
        .a         (fac_data),
        .b         (ifac_r_data),
        .in_tag    ({rd_ok_reg, rd_beyond_reg, ifac_d_data}),
        .out_valid (m1_valid),
        .res       (m1_res),
        .out_tag   (m1_tag)
    );

    bmp_mulmod #(
        .TAG_W (2)
    ) u_mul_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m1_valid),
        .a         (m1_res),
        .b         (m1_tag[VAL_W-1:0]),
        .in_tag    (m1_tag[VAL_W+1:VAL_W]),
        .out_valid (m2_valid),
        .res       (m2_res),
        .out_tag   (m2_tag)
    );

    always_comb
    begin
        res_in.coefficient  = m2_tag[1] ? m2_res : '0;
        res_in.beyond_table = m2_tag[0];
    end

    bmp_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (m2_valid),
        .wdata (res_in),
        .full  (out_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign result = result_t'(res_bits);

endmodule

// ===== hdl/binomial_mod_prime.sv =====
// Binomial coefficient C(n,r) mod 1000003 from factorial and inverse-factorial tables.
// After reset the tables are built for indexes 0 .. min(TABLE_LIMIT, 32767): factorials
// upward, one Fermat inverse of the top factorial by square-and-multiply, then inverse
// factorials downward, each step an issue into a 7-stage modular multiplier and a wait for
// its result. Queries pushed meanwhile wait in a 4-word queue; no result appears before the
// build ends. Afterwards the block takes one query per cycle and gives one result per cycle
// while the back end is not stalled; a query passes through the job queue, a registered
// table read, two pipelined multiply-reduce units of 7 stages each and the output queue.
// Up to 32 results may wait unpopped; the back end stalls once 32 are queued or in flight.
// Negative n or r, or r above n, give zero; n above TABLE_LIMIT gives zero with
// beyond_table set.
module binomial_mod_prime #(
    parameter int TABLE_LIMIT = 4095
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  bmp_pkg::query_t   query,
    input  logic              pop,
    output logic              empty,
    output bmp_pkg::result_t  result
);

    import bmp_pkg::*;

    localparam int TABLE_TOP   = (TABLE_LIMIT < IDX_MAX) ? TABLE_LIMIT : IDX_MAX;
    localparam int TABLE_DEPTH = TABLE_TOP + 1;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    logic             ready;
    tbl_wr_t          fac_wr;
    tbl_wr_t          ifac_wr;
    logic             job_pop;
    logic             job_empty;
    job_t             job;
    logic [VAL_W-1:0] fac_data;
    logic [VAL_W-1:0] ifac_r_data;
    logic [VAL_W-1:0] ifac_d_data;

    bmp_init #(
        .TABLE_TOP (TABLE_TOP)
    ) u_init (
        .clk     (clk),
        .rst_n   (rst_n),
        .ready   (ready),
        .fac_wr  (fac_wr),
        .ifac_wr (ifac_wr)
    );

    bmp_front #(
        .TABLE_TOP (TABLE_TOP)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .query     (query),
        .job_pop   (job_pop),
        .job_empty (job_empty),
        .job       (job)
    );

    bmp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_fac_ram (
        .clk   (clk),
        .we    (fac_wr.en),
        .waddr (fac_wr.addr[ADDR_W-1:0]),
        .wdata (fac_wr.data),
        .raddr (job.n[ADDR_W-1:0]),
        .rdata (fac_data)
    );

    // two copies of the inverse table for the two reads per query
    bmp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ifac_r_ram (
        .clk   (clk),
        .we    (ifac_wr.en),
        .waddr (ifac_wr.addr[ADDR_W-1:0]),
        .wdata (ifac_wr.data),
        .raddr (job.r[ADDR_W-1:0]),
        .rdata (ifac_r_data)
    );

    bmp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ifac_d_ram (
        .clk   (clk),
        .we    (ifac_wr.en),
        .waddr (ifac_wr.addr[ADDR_W-1:0]),
        .wdata (ifac_wr.data),
        .raddr (job.d[ADDR_W-1:0]),
        .rdata (ifac_d_data)
    );

    bmp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .ready       (ready),
        .job_empty   (job_empty),
        .job         (job),
        .job_pop     (job_pop),
        .fac_data    (fac_data),
        .ifac_r_data (ifac_r_data),
        .ifac_d_data (ifac_d_data),
        .pop         (pop),
        .empty       (empty),
        .result      (result)
    );

endmodule

// ===== hdl/bmp_checker.sv =====
module bmp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             push,
    input logic             full,
    input bmp_pkg::query_t  query,
    input logic             pop,
    input logic             empty,
    input bmp_pkg::result_t result
);

    import bmp_pkg::*;

    logic [15:0] outstanding_reg, outstanding_next;
    logic        in_word;
    logic        out_word;

    assign in_word  = push && !full;
    assign out_word = pop && !empty;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (in_word && !out_word)
        begin
            outstanding_next = outstanding_reg + 16'd1;
        end
        else if (out_word && !in_word)
        begin
            outstanding_next = outstanding_reg - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // no result word without a query word behind it
    a_no_extra_word: assert property (@(posedge clk) disable iff (!rst_n)
        (outstanding_reg == 16'd0) |-> empty)
        else $error("result word with no query outstanding");

    a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.beyond_table) |-> (result.coefficient == '0))
        else $error("beyond_table set with nonzero coefficient");

    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.coefficient < PRIME))
        else $error("coefficient not reduced");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result word changed or vanished");

endmodule

bind binomial_mod_prime bmp_checker u_bmp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .query  (query),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

// ===== dv/bmp_checker.sv =====
`timescale 1ns / 1ps

module tb_bmp_checker #(
    parameter int TABLE_LIMIT = 4095
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             full,
    input  bmp_pkg::query_t  query,
    input  logic             pop,
    input  logic             empty,
    input  bmp_pkg::result_t result,
    output int               mismatches,
    output int               outstanding,
    output int               checked,
    output int               nonzero_seen,
    output int               beyond_seen
);

    logic [bmp_pkg::VAL_W-1:0] fact_tbl     [0:TABLE_LIMIT];
    logic [bmp_pkg::VAL_W-1:0] inv_fact_tbl [0:TABLE_LIMIT];

    bmp_pkg::result_t due_binoms [$];

    int n_bad;
    int n_checked;
    int n_nonzero;
    int n_beyond;

    function automatic logic [19:0] mul_mod_p(logic [19:0] a, logic [19:0] b);
        logic [39:0] prod;
        prod = 40'(a) * 40'(b);
        return 20'(prod % 40'(bmp_pkg::PRIME));
    endfunction

    // a^(p-2) by square-and-multiply
    function automatic logic [19:0] fermat_inv(logic [19:0] a);
        logic [19:0] acc;
        logic [19:0] sq;
        logic [19:0] e;
        acc = 20'd1;
        sq  = a;
        e   = bmp_pkg::PRIME - 20'd2;
        while (e != 0)
        begin
            if (e[0])
                acc = mul_mod_p(acc, sq);
            sq = mul_mod_p(sq, sq);
            e  = e >> 1;
        end
        return acc;
    endfunction

    function automatic bmp_pkg::result_t binom_of(bmp_pkg::query_t q);
        int n;
        int r;
        bmp_pkg::result_t res;
        n   = $signed(q.total_count);
        r   = $signed(q.chosen_count);
        res = '0;
        if (n > TABLE_LIMIT)
            res.beyond_table = 1'b1;
        else if (n >= 0 && r >= 0 && r <= n)
            res.coefficient = mul_mod_p(mul_mod_p(fact_tbl[n], inv_fact_tbl[r]),
                                        inv_fact_tbl[n-r]);
        return res;
    endfunction

    initial
    begin
        fact_tbl[0] = 20'd1;
        for (int i = 1; i <= TABLE_LIMIT; i++)
            fact_tbl[i] = mul_mod_p(fact_tbl[i-1], 20'(i % 1000003));
        for (int i = 0; i <= TABLE_LIMIT; i++)
            inv_fact_tbl[i] = fermat_inv(fact_tbl[i]);
    end

    always @(posedge clk or negedge rst_n)
    begin
        bmp_pkg::result_t want;
        if (!rst_n)
        begin
            due_binoms.delete();
            n_bad        = 0;
            n_checked    = 0;
            n_nonzero    = 0;
            n_beyond     = 0;
            mismatches   <= 0;
            outstanding  <= 0;
            checked      <= 0;
            nonzero_seen <= 0;
            beyond_seen  <= 0;
        end
        else
        begin
            // a query takes many cycles, so the word popped now never belongs to
            // the query pushed at this edge
            if (pop && !empty)
            begin
                if (due_binoms.size() == 0)
                begin
                    $error("result word with no query waiting: coefficient %0d beyond_table %0d",
                           result.coefficient, result.beyond_table);
                    n_bad++;
                end
                else
                begin
                    want = due_binoms.pop_front();
                    n_checked++;
                    if (want.coefficient != 0)
                        n_nonzero++;
                    if (want.beyond_table)
                        n_beyond++;
                    if (result.coefficient !== want.coefficient)
                    begin
                        $error("coefficient: expected %0d, actual %0d",
                               want.coefficient, result.coefficient);
                        n_bad++;
                    end
                    if (result.beyond_table !== want.beyond_table)
                    begin
                        $error("beyond_table: expected %0d, actual %0d",
                               want.beyond_table, result.beyond_table);
                        n_bad++;
                    end
                end
            end
            if (push && !full)
                due_binoms = {due_binoms, binom_of(query)};
            mismatches   <= n_bad;
            outstanding  <= due_binoms.size();
            checked      <= n_checked;
            nonzero_seen <= n_nonzero;
            beyond_seen  <= n_beyond;
        end
    end

endmodule

// ===== dv/tb_binomial_mod_prime.sv =====
`timescale 1ns / 1ps

module tb_binomial_mod_prime;

    localparam int TBL_LIMIT   = 4095;
    localparam int RAND_QUERIES = 1800;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AFTER  = 200;
    localparam int HOLD_CYCLES = 400;

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    bmp_pkg::query_t  query;
    logic             pop;
    logic             empty;
    bmp_pkg::result_t result;

    int mismatches;
    int outstanding;
    int checked;
    int nonzero_seen;
    int beyond_seen;
    int cycles;

    binomial_mod_prime #(
        .TABLE_LIMIT (TBL_LIMIT)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .query  (query),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    tb_bmp_checker #(
        .TABLE_LIMIT (TBL_LIMIT)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .query        (query),
        .pop          (pop),
        .empty        (empty),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked),
        .nonzero_seen (nonzero_seen),
        .beyond_seen  (beyond_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        push  = 1'b0;
        pop   = 1'b0;
        query = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("binomial_mod_prime regression: fail");
            $finish;
        end
    end

    initial cycles = 0;

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic send_query(input logic [15:0] n, input logic [15:0] r, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push               <= 1'b1;
        query.total_count  <= n;
        query.chosen_count <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // result side: random pop gaps, plus one long hold so the block backs up
    initial
    begin
        int gap;
        int popped;
        popped = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        pop <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                popped++;
                gap = (popped == HOLD_AFTER) ? HOLD_CYCLES : pick_gap();
                if (gap > 0)
                begin
                    @(negedge clk);
                    pop <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                    @(negedge clk);
                    pop <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        int dir_n [0:21] = '{0, 1, 1, 2, 10, 100, 4095, 4095, 4095, 4094, 4096, 32767,
                             32767, -1, -32768, -1, 5, 0, 10, 4095, -32768, 2};
        int dir_r [0:21] = '{0, 0, 1, 1, 3, 50, 0, 4095, 2047, 4095, 0, 5,
                             -32768, 0, -32768, -1, -1, 32767, 11, -1, 32767, 1};
        logic [15:0] tn;
        logic [15:0] tr;
        int roll;

        wait (rst_n === 1'b1);

        // extremes, sign cases, r above n, top of the table and just past it
        foreach (dir_n[i])
            send_query(dir_n[i][15:0], dir_r[i][15:0], pick_gap());

        for (int k = 0; k < RAND_QUERIES; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                tn = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, TBL_LIMIT))
                                                 : 16'($urandom_range(0, 64));
                tr = 16'($urandom_range(0, tn));
            end
            else if (roll < 63)
            begin
                tn = 16'($urandom_range(0, TBL_LIMIT - 1));
                tr = 16'($urandom_range(tn + 1, 32767));
            end
            else if (roll < 73)
            begin
                tn = 16'($urandom_range(0, 65535));
                tr = 16'($urandom_range(0, 65535));
                if ($urandom_range(0, 1) == 0)
                    tn[15] = 1'b1;
                else
                    tr[15] = 1'b1;
            end
            else if (roll < 85)
            begin
                tn = 16'($urandom_range(TBL_LIMIT + 1, 32767));
                tr = 16'($urandom_range(0, 65535));
            end
            else
            begin
                tn = 16'($urandom_range(0, 65535));
                tr = 16'($urandom_range(0, 65535));
            end
            send_query(tn, tr, pick_gap());
        end

        @(negedge clk);
        push <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("checked %0d result words: %0d nonzero coefficients, %0d beyond the table",
                 checked, nonzero_seen, beyond_seen);
        $display("queries spanned negative fields, r above n, full table range and a long drain stall");
        if (mismatches == 0)
            $display("binomial_mod_prime regression: pass");
        else
            $display("binomial_mod_prime regression: fail");
        $finish;
    end

endmodule
